[rtl/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants of the ChaCha20 byte-stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

  // Input constant row of the ChaCha20 state ("expand 32-byte k").
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Block counter value after reset.
  localparam logic [31:0] COUNTER_RESET = 32'd1;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = QPTR_W + 1;

  // 10 double rounds, each 8 steps of four parallel add-xor-rotate ops.
  localparam int ROUND_STEPS = 80;
  localparam int STEP_W      = $clog2(ROUND_STEPS);

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  typedef enum logic [2:0] {
    REG_KEY_WORD_0      = 3'd0,
    REG_KEY_WORD_1      = 3'd1,
    REG_KEY_WORD_2      = 3'd2,
    REG_KEY_WORD_3      = 3'd3,
    REG_NONCE_LOW       = 3'd4,
    REG_NONCE_HIGH      = 3'd5,
    REG_INITIAL_COUNTER = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } key_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One classified byte on its way from front to back.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  pos;
    logic        need_block;
    logic [31:0] counter;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } back_state_t;

endpackage

[rtl/chacha_front.sv]
// ----------------------------------------------------------------------------
// chacha_front
// Accepts bytes, tracks the offset and block counter of the message and
// marks the bytes that need a fresh keystream block.
// ----------------------------------------------------------------------------
module chacha_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  chacha_pkg::in_item_t push_item,
  input  logic [31:0]          initial_counter,
  input  logic                 ctr_load,
  input  logic [31:0]          ctr_value,
  input  logic                 q_full,
  output logic                 q_wr,
  output chacha_pkg::job_t     q_entry
);

  logic [31:0] block_count;
  logic [5:0]  byte_position;
  logic        store_valid;
  logic        need_block;

  assign full       = q_full;
  assign q_wr       = push && !q_full;
  assign need_block = !store_valid || (byte_position == 6'd0);

  always_comb begin
    q_entry.data_byte  = push_item.data_byte;
    q_entry.last_byte  = push_item.last_byte;
    q_entry.pos        = byte_position;
    q_entry.need_block = need_block;
    q_entry.counter    = block_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= chacha_pkg::COUNTER_RESET;
      byte_position <= 6'd0;
      store_valid   <= 1'b0;
    end else if (q_wr) begin
      if (push_item.last_byte) begin
        byte_position <= 6'd0;
        store_valid   <= 1'b0;
        block_count   <= initial_counter;
      end else begin
        byte_position <= byte_position + 6'd1;
        store_valid   <= 1'b1;
        if (need_block) begin
          block_count <= block_count + 32'd1;
        end
      end
    end else if (ctr_load && !store_valid) begin
      block_count <= ctr_value;
    end
  end

  // Between messages the offset always sits at the start of a block.
  a_idle_offset_zero: assert property (@(posedge clk) disable iff (rst)
    !store_valid |-> (byte_position == 6'd0))
    else $error("offset not zero outside a message");

endmodule

[rtl/chacha_queue.sv]
// ----------------------------------------------------------------------------
// chacha_queue
// Short job queue that decouples the front from the block generator.
// ----------------------------------------------------------------------------
module chacha_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  chacha_pkg::job_t wr_entry,
  output logic             full,
  input  logic             rd,
  output chacha_pkg::job_t rd_entry,
  output logic             empty
);

  chacha_pkg::job_t                slots [chacha_pkg::QUEUE_DEPTH];
  logic [chacha_pkg::QPTR_W-1:0]   wr_ptr;
  logic [chacha_pkg::QPTR_W-1:0]   rd_ptr;
  logic [chacha_pkg::QCOUNT_W-1:0] count;

  assign full     = (count == chacha_pkg::QCOUNT_W'(chacha_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= chacha_pkg::QCOUNT_W'(chacha_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

[rtl/chacha_back.sv]
// ----------------------------------------------------------------------------
// chacha_back
// Runs the ChaCha20 block function one round step per cycle when a job asks
// for a new block, then XORs each job's byte with its keystream byte.
// ----------------------------------------------------------------------------
module chacha_back (
  input  logic                  clk,
  input  logic                  rst,
  input  chacha_pkg::key_cfg_t  cfg,
  input  logic                  q_empty,
  input  chacha_pkg::job_t      q_head,
  output logic                  q_rd,
  output logic                  empty,
  input  logic                  pop,
  output chacha_pkg::out_item_t pop_item
);

  chacha_pkg::back_state_t state, state_next;
  logic [chacha_pkg::STEP_W-1:0] step, step_next;
  chacha_pkg::block_t            w, w_next, w_round, init;
  logic                          out_valid, out_valid_next;
  chacha_pkg::out_item_t         out_item, out_item_next;

  logic                          diag;
  logic [1:0]                    sub;
  logic [1:0]                    jb [4];
  logic [1:0]                    jc [4];
  logic [1:0]                    jd [4];
  chacha_pkg::word_t             wa [4];
  chacha_pkg::word_t             wb [4];
  chacha_pkg::word_t             wc [4];
  chacha_pkg::word_t             wd [4];
  chacha_pkg::word_t             ks_word;
  logic [7:0]                    ks_byte;
  logic                          slot_free;

  function automatic chacha_pkg::word_t rotl(input chacha_pkg::word_t v,
                                             input logic [1:0] s);
    chacha_pkg::word_t r;
    case (s)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  // Initial state matrix for the block of the job at the queue head.
  always_comb begin
    init[0] = chacha_pkg::SIGMA_0;
    init[1] = chacha_pkg::SIGMA_1;
    init[2] = chacha_pkg::SIGMA_2;
    init[3] = chacha_pkg::SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = cfg.key[i][31:0];
      init[5 + 2 * i] = cfg.key[i][63:32];
    end
    init[12] = q_head.counter;
    init[13] = cfg.nonce_low[31:0];
    init[14] = cfg.nonce_low[63:32];
    init[15] = cfg.nonce_high;
  end

  // One step of four quarter rounds. Diagonal rounds rotate rows b, c and d
  // by one, two and three columns.
  assign diag = step[2];
  assign sub  = step[1:0];

  always_comb begin
    w_round = w;
    for (int j = 0; j < 4; j++) begin
      jb[j] = 2'(j) + {1'b0, diag};
      jc[j] = 2'(j) + {diag, 1'b0};
      jd[j] = 2'(j) + {diag, diag};
      wa[j] = w[{2'b00, 2'(j)}];
      wb[j] = w[{2'b01, jb[j]}];
      wc[j] = w[{2'b10, jc[j]}];
      wd[j] = w[{2'b11, jd[j]}];
      if (!sub[0]) begin
        w_round[{2'b00, 2'(j)}] = wa[j] + wb[j];
        w_round[{2'b11, jd[j]}] = rotl(wd[j] ^ (wa[j] + wb[j]), sub);
      end else begin
        w_round[{2'b10, jc[j]}] = wc[j] + wd[j];
        w_round[{2'b01, jb[j]}] = rotl(wb[j] ^ (wc[j] + wd[j]), sub);
      end
    end
  end

  assign ks_word   = w[q_head.pos[5:2]];
  assign ks_byte   = 8'(ks_word >> {q_head.pos[1:0], 3'b000});
  assign slot_free = !out_valid || pop;

  always_comb begin
    state_next     = state;
    step_next      = step;
    w_next         = w;
    q_rd           = 1'b0;
    out_valid_next = out_valid && !pop;
    out_item_next  = out_item;
    unique case (state)
      chacha_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.need_block) begin
            w_next     = init;
            step_next  = '0;
            state_next = chacha_pkg::ST_ROUND;
          end else if (slot_free) begin
            q_rd           = 1'b1;
            out_valid_next = 1'b1;
            out_item_next  = '{out_byte: q_head.data_byte ^ ks_byte,
                               out_last: q_head.last_byte};
          end
        end
      end
      chacha_pkg::ST_ROUND: begin
        w_next    = w_round;
        step_next = step + 1'b1;
        if (step == chacha_pkg::STEP_W'(chacha_pkg::ROUND_STEPS - 1)) begin
          state_next = chacha_pkg::ST_FINAL;
        end
      end
      chacha_pkg::ST_FINAL: begin
        for (int i = 0; i < 16; i++) begin
          w_next[i] = w[i] + init[i];
        end
        state_next = chacha_pkg::ST_EMIT;
      end
      chacha_pkg::ST_EMIT: begin
        if (slot_free) begin
          q_rd           = 1'b1;
          out_valid_next = 1'b1;
          out_item_next  = '{out_byte: q_head.data_byte ^ ks_byte,
                             out_last: q_head.last_byte};
          state_next     = chacha_pkg::ST_IDLE;
        end
      end
      default: state_next = chacha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chacha_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    w        <= w_next;
    out_item <= out_item_next;
  end

  assign empty    = !out_valid;
  assign pop_item = out_item;

  // A byte that starts a block leaves only after its block is complete.
  a_block_before_byte: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (state == chacha_pkg::ST_EMIT || !q_head.need_block))
    else $error("byte consumed before its keystream block was made");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("job queue read while empty");

  a_full_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == chacha_pkg::ST_FINAL) |->
      ($past(state) == chacha_pkg::ST_ROUND &&
       $past(step) == chacha_pkg::STEP_W'(chacha_pkg::ROUND_STEPS - 1)))
    else $error("final addition reached without all round steps");

endmodule

[rtl/chacha20_keystream_xor.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// ChaCha20 (20 rounds) byte-stream cipher: each byte is XORed with the next
// keystream byte; a last-byte flag ends the message.
// ----------------------------------------------------------------------------
// Usage: the key (four 64-bit words), the 96-bit nonce and the initial block
// counter are written through wr_en/wr_index/wr_data while the block is idle.
// Bytes enter as beats on push/full and results leave as beats on
// empty/pop, one result beat per input beat, in order.
// A beat that needs no new keystream block passes through the job queue
// and the output register to the result port. The first beat of a message
// and every 64th beat after it start a new block: the block function runs
// on one shared set of four quarter-round adders, one step per cycle, so
// such a beat goes through a load, 80 round steps, a final add and an emit
// in the back end. Other beats pass at one per cycle while the receiver
// keeps popping. A four-entry job queue lets the input keep accepting beats
// while a block is generated, until the queue fills and full rises.
// A single output register holds the oldest result; when the receiver
// stalls, the back end waits and the queue absorbs the input until full.
// Synchronous reset clears the key and nonce to zero, sets the initial
// counter to one and drops all queued and pending beats.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [63:0]           wr_data,
  input  logic                  push,
  output logic                  full,
  input  chacha_pkg::in_item_t  push_item,
  output logic                  empty,
  input  logic                  pop,
  output chacha_pkg::out_item_t pop_item
);

  chacha_pkg::key_cfg_t cfg;
  logic [31:0]          initial_counter;
  logic                 ctr_load;

  logic                 q_full;
  logic                 q_empty;
  logic                 q_wr;
  logic                 q_rd;
  chacha_pkg::job_t     q_entry;
  chacha_pkg::job_t     q_head;

  // Writing the initial counter also reloads the running block counter when
  // no message is in progress; the front decides that.
  assign ctr_load = wr_en && (wr_index == chacha_pkg::REG_INITIAL_COUNTER);

  // Configuration registers. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg             <= '0;
      initial_counter <= chacha_pkg::COUNTER_RESET;
    end else if (wr_en) begin
      unique case (chacha_pkg::cfg_reg_t'(wr_index))
        chacha_pkg::REG_KEY_WORD_0:      cfg.key[0]      <= wr_data;
        chacha_pkg::REG_KEY_WORD_1:      cfg.key[1]      <= wr_data;
        chacha_pkg::REG_KEY_WORD_2:      cfg.key[2]      <= wr_data;
        chacha_pkg::REG_KEY_WORD_3:      cfg.key[3]      <= wr_data;
        chacha_pkg::REG_NONCE_LOW:       cfg.nonce_low   <= wr_data;
        chacha_pkg::REG_NONCE_HIGH:      cfg.nonce_high  <= wr_data[31:0];
        chacha_pkg::REG_INITIAL_COUNTER: initial_counter <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Front: takes beats and tags those that begin a keystream block.
  chacha_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .push_item       (push_item),
    .initial_counter (initial_counter),
    .ctr_load        (ctr_load),
    .ctr_value       (wr_data[31:0]),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_entry         (q_entry)
  );

  chacha_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_entry),
    .full     (q_full),
    .rd       (q_rd),
    .rd_entry (q_head),
    .empty    (q_empty)
  );

  // Back: block function and keystream XOR into the output register.
  chacha_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .pop_item (pop_item)
  );

endmodule

[dv/chacha20_keystream_xor_checker.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_checker
// Watches the configuration, input and result channels of the ChaCha20
// byte cipher, predicts every result beat and compares it in order.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_checker
  import chacha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        push,
  input  logic        full,
  input  in_item_t    push_item,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   pop_item,
  output int          mismatch_count,
  output int          results_owed,
  output int          blocks_made,
  output int          counter_wraps
);

  logic [3:0][63:0] key_shadow;
  logic [63:0]      nonce_lo_shadow;
  logic [31:0]      nonce_hi_shadow;
  logic [31:0]      start_counter;
  logic [31:0]      block_counter;
  logic [5:0]       stream_offset;
  logic             message_open;
  logic [7:0]       keystream [64];
  word_t            mix [16];
  out_item_t        expected_bytes [$];

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
  endfunction

  // Builds the next 64-byte keystream block from the current key, nonce and
  // block counter, then advances the counter.
  function automatic void refill_keystream();
    word_t seed [16];
    word_t sum;
    seed[0] = SIGMA_0;
    seed[1] = SIGMA_1;
    seed[2] = SIGMA_2;
    seed[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2 * i] = key_shadow[i][31:0];
      seed[5 + 2 * i] = key_shadow[i][63:32];
    end
    seed[12] = block_counter;
    seed[13] = nonce_lo_shadow[31:0];
    seed[14] = nonce_lo_shadow[63:32];
    seed[15] = nonce_hi_shadow;
    for (int i = 0; i < 16; i++) mix[i] = seed[i];
    for (int r = 0; r < 10; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = mix[i] + seed[i];
      for (int k = 0; k < 4; k++) keystream[4 * i + k] = sum[8 * k +: 8];
    end
    if (block_counter == 32'hffff_ffff) counter_wraps++;
    block_counter = block_counter + 32'd1;
    blocks_made++;
  endfunction

  function automatic void take_config(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
        key_shadow[idx[1:0]] = val;
      REG_NONCE_LOW:  nonce_lo_shadow = val;
      REG_NONCE_HIGH: nonce_hi_shadow = val[31:0];
      REG_INITIAL_COUNTER: begin
        // The running counter follows only when no message is open.
        start_counter = val[31:0];
        if (!message_open) block_counter = val[31:0];
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(input in_item_t beat);
    out_item_t want;
    if (!message_open || stream_offset == 6'd0) begin
      refill_keystream();
      message_open = 1'b1;
    end
    want.out_byte = beat.data_byte ^ keystream[stream_offset];
    want.out_last = beat.last_byte;
    expected_bytes.push_back(want);
    stream_offset = stream_offset + 6'd1;
    if (beat.last_byte) begin
      stream_offset = 6'd0;
      message_open  = 1'b0;
      block_counter = start_counter;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: result beat with nothing expected, got byte %02h last %b",
               $time, got.out_byte, got.out_last);
      mismatch_count++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte mismatch, expected %02h, got %02h",
               $time, want.out_byte, got.out_byte);
      mismatch_count++;
    end
    if (got.out_last !== want.out_last) begin
      $display("%0t: out_last mismatch, expected %b, got %b",
               $time, want.out_last, got.out_last);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_shadow      = '0;
      nonce_lo_shadow = '0;
      nonce_hi_shadow = '0;
      start_counter   = COUNTER_RESET;
      block_counter   = COUNTER_RESET;
      stream_offset   = '0;
      message_open    = 1'b0;
      blocks_made     = 0;
      counter_wraps   = 0;
      expected_bytes.delete();
    end else begin
      if (wr_en) take_config(wr_index, wr_data);
      // Results first, so a beat pushed in this cycle cannot cover a stray one.
      if (pop && !empty) check_result(pop_item);
      if (push && !full) predict_byte(push_item);
    end
    results_owed = expected_bytes.size();
  end

endmodule

[dv/chacha20_keystream_xor_tb.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_tb
// Drives byte messages through the ChaCha20 keystream XOR block under several
// key, nonce and counter settings, with random idling on both sides and one
// long receiver hold-off; a checker module predicts and compares each beat.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_tb;
  import chacha_pkg::*;

  // Index 7 is not a register; writes to it must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;

  localparam int TOTAL_BYTES = 800;
  localparam int IDLE_PCT    = 7;
  // Between these beat counts neither side idles, so back-to-back traffic
  // runs into block generation.
  localparam int QUIET_FROM  = 450;
  localparam int QUIET_TO    = 600;
  // Once this many bytes have gone in, the receiver stops popping for a long
  // stretch so that the job queue and output register fill and full rises.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  // Block generation and the receiver hold-off both end well within this
  // limit, so a correct run never goes this long without moving a beat.
  localparam int STALL_LIMIT = 4000;
  // A beat needing no new block passes the job queue and the output register.
  localparam int SETTLE      = 4;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;
  logic        push;
  logic        full;
  in_item_t    push_item;
  logic        empty;
  logic        pop;
  out_item_t   pop_item;

  int mismatch_count;
  int results_owed;
  int blocks_made;
  int counter_wraps;

  int bytes_sent;
  int messages_done;
  int phases_done;
  int results_taken;
  bit hold_req;
  bit hold_done;

  chacha20_keystream_xor uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .push_item(push_item),
    .empty    (empty),
    .pop      (pop),
    .pop_item (pop_item)
  );

  chacha20_keystream_xor_checker cipher_check (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .push          (push),
    .full          (full),
    .push_item     (push_item),
    .empty         (empty),
    .pop           (pop),
    .pop_item      (pop_item),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed),
    .blocks_made   (blocks_made),
    .counter_wraps (counter_wraps)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One register write; the enable and data are set at a falling edge, and the
  // enable drops again once the write has landed at a rising edge.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Offers one byte beat and returns at the rising edge where it is taken.
  // push stays high from one beat to the next, so back-to-back beats never
  // see it dropped and raised in the same time step.
  task automatic send_byte(input logic [7:0] d, input logic l);
    in_item_t beat;
    beat.data_byte = d;
    beat.last_byte = l;
    @(negedge clk);
    if (bytes_sent < QUIET_FROM || bytes_sent >= QUIET_TO) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push      <= 1'b1;
    push_item <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    if (bytes_sent == HOLD_AT) hold_req = 1'b1;
    if (l) messages_done++;
  endtask

  // A message of random bytes; with close clear the final byte is not
  // flagged, so the message is still open when the next settings go in.
  task automatic send_message(input int len, input bit close);
    for (int i = 0; i < len; i++)
      send_byte($urandom_range(255), close && (i == len - 1));
  endtask

  // Stops offering and waits until every predicted result has been popped,
  // plus a settling wait so the block is idle before registers change.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // New random settings for one phase. Each register is rewritten about half
  // the time with zero, all ones or a random value; the first phase rewrites
  // everything and starts the counter at its top so it wraps within a message.
  task automatic shuffle_config(input bit force_wrap);
    logic [63:0] v;
    for (int r = REG_KEY_WORD_0; r <= REG_INITIAL_COUNTER; r++) begin
      if (force_wrap || $urandom_range(1) == 1) begin
        case ($urandom_range(3))
          0:       v = '0;
          1:       v = '1;
          default: v = {$urandom, $urandom};
        endcase
        if (r == REG_INITIAL_COUNTER) begin
          if (force_wrap) v = {$urandom, 32'hffff_ffff};
          else if ($urandom_range(3) == 0) v = {$urandom, 32'hffff_fffe};
        end
        write_reg(r[2:0], v);
      end
    end
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
  endtask

  // Receiver: pops at random, except for an idle-free stretch and the one
  // long hold-off, whose length it counts itself.
  initial begin : receiver
    int hold_left;
    hold_left     = 0;
    hold_done     = 1'b0;
    results_taken = 0;
    pop           = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) results_taken++;
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (results_taken >= QUIET_FROM && results_taken < QUIET_TO) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run if no beat and no register write moves for too
  // long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || wr_en || (push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int  len;
    int  msgs;
    bit  open_end;
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = '0;
    wr_data       = '0;
    push          = 1'b0;
    push_item     = '0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    messages_done = 0;
    phases_done   = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: all-zero key and nonce, counter one. Both data
    // extremes and both flag values go through.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    drain();

    // Every register at all ones, plus a write to the unused index that
    // must leave the settings alone.
    write_reg(REG_KEY_WORD_0, '1);
    write_reg(REG_KEY_WORD_1, '1);
    write_reg(REG_KEY_WORD_2, '1);
    write_reg(REG_KEY_WORD_3, '1);
    write_reg(REG_NONCE_LOW, '1);
    write_reg(REG_NONCE_HIGH, '1);
    write_reg(REG_INITIAL_COUNTER, '1);
    write_reg(REG_SPARE, 64'h0123_4567_89ab_cdef);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
    drain();

    // A well-known key and nonce; the message is left open across a
    // change of key, nonce and counter. The open block must be kept, and
    // the new counter only applies from the next message on.
    write_reg(REG_KEY_WORD_0, 64'h0706_0504_0302_0100);
    write_reg(REG_KEY_WORD_1, 64'h0f0e_0d0c_0b0a_0908);
    write_reg(REG_KEY_WORD_2, 64'h1716_1514_1312_1110);
    write_reg(REG_KEY_WORD_3, 64'h1f1e_1d1c_1b1a_1918);
    write_reg(REG_NONCE_LOW, 64'h4a00_0000_0000_0000);
    write_reg(REG_NONCE_HIGH, 64'h0);
    write_reg(REG_INITIAL_COUNTER, 64'h1);
    send_byte(8'h4c, 1'b0);
    send_byte(8'h61, 1'b0);
    drain();
    write_reg(REG_KEY_WORD_2, '0);
    write_reg(REG_NONCE_HIGH, 64'hffff_ffff_0000_0001);
    write_reg(REG_INITIAL_COUNTER, 64'h7);
    send_byte(8'h64, 1'b0);
    send_byte(8'h69, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // Counter written with no message open: it loads at once.
    write_reg(REG_INITIAL_COUNTER, 64'h0);
    send_byte(8'h7f, 1'b1);
    drain();

    // Random phases: new settings, then a few messages of random bytes.
    // Most messages are short; about one in ten runs over one or more block
    // boundaries. Now and then the last message is left open into the next
    // phase's register writes.
    while (bytes_sent < TOTAL_BYTES) begin
      shuffle_config(phases_done == 0);
      msgs = $urandom_range(1, 4);
      for (int m = 0; m < msgs; m++) begin
        if (phases_done == 0 && m == 0) len = 130;
        else if ($urandom_range(9) == 0) len = $urandom_range(65, 160);
        else len = $urandom_range(1, 24);
        open_end = (m == msgs - 1) && ($urandom_range(4) == 0);
        send_message(len, !open_end);
      end
      drain();
      phases_done++;
    end

    $display("Run covered %0d bytes in %0d closed messages over %0d random settings.",
             bytes_sent, messages_done, phases_done);
    $display("Predicted %0d keystream blocks, %0d counter wraps, one %0d-cycle receiver hold.",
             blocks_made, counter_wraps, HOLD_CYCLES);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
